// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the frame store RTL.
// Depends on nothing; the including module supplies the clock and reset names.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assertion on the block clock aclk, disabled while aresetn is low.
`define PNFP_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Assertion on an explicit clock and active-low reset.
`define PNFP_ASSERT_CLK(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

`endif

// ===== rtl/pnfp_pkg.sv =====
// Package for the packed nibble frame store: geometry, codes, state type and
// the palette request struct. Depends on nothing.
package pnfp_pkg;

    localparam int FRAME_WIDTH  = 320;
    localparam int FRAME_HEIGHT = 240;
    localparam int PALETTE_SIZE = 16;

    localparam int ROW_BYTES   = FRAME_WIDTH / 2;
    localparam int STORE_BYTES = (FRAME_WIDTH * FRAME_HEIGHT) / 2;
    localparam int STORE_AW    = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;
    localparam int LIN_W       = $clog2(ROW_BYTES * 1023 + 512);

    localparam int COORD_W  = 10;
    localparam int NIB_W    = 4;
    localparam int PAL_AW   = 4;
    localparam int COLOR_W  = 16;
    localparam int BYTE_W   = 8;

    localparam logic [1:0] ACT_PLOT    = 2'd0;
    localparam logic [1:0] ACT_PALETTE = 2'd1;
    localparam logic [1:0] ACT_READ    = 2'd2;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_PLOT_RD,
        S_READ_FRAME,
        S_READ_PAL
    } state_t;

    typedef struct packed {
        logic                we;
        logic [PAL_AW-1:0]   waddr;
        logic [COLOR_W-1:0]  wdata;
        logic                re;
        logic [PAL_AW-1:0]   raddr_even;
        logic [PAL_AW-1:0]   raddr_odd;
    } pal_req_t;

endpackage

// ===== rtl/packed_nibble_framebuffer_palette.sv =====
// Top level of the 4-bit indexed frame store with a 16-entry palette.
// Depends on pnfp_pkg, pnfp_ram, pnfp_palette and assert_macros.svh.
//
// Input words (s_valid/s_ready) carry an action: plot writes one nibble of a
// byte in the frame store, load sets one palette entry, read returns the
// palette colours of both pixels of one byte. Only read produces an output
// word (m_valid/m_ready) with pixel_even, pixel_odd and in_range.
// After reset the frame store is swept to zero, one byte per cycle, over all
// STORE_BYTES (38400) bytes; s_ready stays low during the sweep.
// A plot reads the byte from the single-port frame RAM and writes it back
// with the new nibble. A read goes through the frame RAM read, the palette
// read and the output register to its result.
// The block works on one word at a time.
// The output register holds a result while the receiver stalls, and the block
// keeps taking plots and loads meanwhile; a following read waits in its last
// cycle until the output register is free.
`include "assert_macros.svh"

module packed_nibble_framebuffer_palette
    import pnfp_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_action,
    input  logic [COORD_W-1:0] s_x,
    input  logic [COORD_W-1:0] s_y,
    input  logic [NIB_W-1:0]   s_colour,
    input  logic [PAL_AW-1:0]  s_palette_index,
    input  logic [COLOR_W-1:0] s_palette_value,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [COLOR_W-1:0] m_pixel_even,
    output logic [COLOR_W-1:0] m_pixel_odd,
    output logic               m_in_range
);

    state_t state_reg, state_next;
    logic [STORE_AW-1:0] clr_reg, clr_next;
    logic [STORE_AW-1:0] addr_reg, addr_next;
    logic                odd_reg, odd_next;
    logic [NIB_W-1:0]    colour_reg, colour_next;
    logic                inr_reg, inr_next;
    logic                m_valid_reg, m_valid_next;
    logic [COLOR_W-1:0]  even_out_reg, even_out_next;
    logic [COLOR_W-1:0]  odd_out_reg, odd_out_next;
    logic                inr_out_reg, inr_out_next;

    logic [LIN_W-1:0]    lin;
    logic                lin_ok;
    logic                accept;
    logic                ram_en, ram_we;
    logic [STORE_AW-1:0] ram_addr;
    logic [BYTE_W-1:0]   ram_wdata, ram_rdata;
    pal_req_t            pal_req;
    logic [COLOR_W-1:0]  pal_even, pal_odd;

    assign lin    = LIN_W'(ROW_BYTES) * LIN_W'(s_y) + LIN_W'(s_x[COORD_W-1:1]);
    assign lin_ok = lin < LIN_W'(STORE_BYTES);
    assign accept = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLEAR;
            clr_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_reg     <= clr_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        addr_reg     <= addr_next;
        odd_reg      <= odd_next;
        colour_reg   <= colour_next;
        inr_reg      <= inr_next;
        even_out_reg <= even_out_next;
        odd_out_reg  <= odd_out_next;
        inr_out_reg  <= inr_out_next;
    end

    always_comb begin
        state_next    = state_reg;
        clr_next      = clr_reg;
        addr_next     = addr_reg;
        odd_next      = odd_reg;
        colour_next   = colour_reg;
        inr_next      = inr_reg;
        even_out_next = even_out_reg;
        odd_out_next  = odd_out_reg;
        inr_out_next  = inr_out_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        s_ready       = 1'b0;
        ram_en        = 1'b0;
        ram_we        = 1'b0;
        ram_addr      = addr_reg;
        ram_wdata     = '0;
        pal_req       = '0;
        pal_req.waddr = s_palette_index;
        pal_req.wdata = s_palette_value;
        pal_req.raddr_even = ram_rdata[NIB_W-1:0];
        pal_req.raddr_odd  = ram_rdata[BYTE_W-1:NIB_W];

        case (state_reg)
            S_CLEAR: begin
                ram_en   = 1'b1;
                ram_we   = 1'b1;
                ram_addr = clr_reg;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == STORE_AW'(STORE_BYTES - 1)) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                s_ready     = 1'b1;
                addr_next   = lin_ok ? STORE_AW'(lin) : '0;
                odd_next    = s_x[0];
                colour_next = s_colour;
                inr_next    = lin_ok;
                ram_addr    = addr_next;
                if (s_valid) begin
                    case (s_action)
                        ACT_PLOT: begin
                            if (lin_ok) begin
                                ram_en     = 1'b1;
                                state_next = S_PLOT_RD;
                            end
                        end
                        ACT_PALETTE: begin
                            pal_req.we = 1'b1;
                        end
                        ACT_READ: begin
                            ram_en     = 1'b1;
                            state_next = S_READ_FRAME;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_PLOT_RD: begin
                ram_en     = 1'b1;
                ram_we     = 1'b1;
                ram_wdata  = odd_reg ? {colour_reg, ram_rdata[NIB_W-1:0]}
                                     : {ram_rdata[BYTE_W-1:NIB_W], colour_reg};
                state_next = S_IDLE;
            end
            S_READ_FRAME: begin
                pal_req.re = 1'b1;
                state_next = S_READ_PAL;
            end
            S_READ_PAL: begin
                if (!m_valid_reg || m_ready) begin
                    even_out_next = inr_reg ? pal_even : '0;
                    odd_out_next  = inr_reg ? pal_odd : '0;
                    inr_out_next  = inr_reg;
                    m_valid_next  = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    pnfp_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (STORE_BYTES),
        .AW    (STORE_AW)
    ) u_frame_ram (
        .aclk  (aclk),
        .en    (ram_en),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    pnfp_palette u_palette (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .req        (pal_req),
        .rdata_even (pal_even),
        .rdata_odd  (pal_odd)
    );

    assign m_valid      = m_valid_reg;
    assign m_pixel_even = even_out_reg;
    assign m_pixel_odd  = odd_out_reg;
    assign m_in_range   = inr_out_reg;

    `PNFP_ASSERT(a_plot_goes_rmw, (accept && s_action == ACT_PLOT && lin_ok) |=> (state_reg == S_PLOT_RD), "in-range plot did not start its write-back")
    `PNFP_ASSERT(a_ram_write_state, (ram_en && ram_we) |-> (state_reg == S_CLEAR || state_reg == S_PLOT_RD), "frame RAM written outside sweep or write-back")
    `PNFP_ASSERT(a_result_held, $fell(m_valid_reg) |-> $past(m_ready), "result dropped without handshake")
    `PNFP_ASSERT(a_out_of_range_zero, (m_valid_reg && !inr_out_reg) |-> (even_out_reg == '0 && odd_out_reg == '0), "out-of-range read carries colour")

endmodule

// ===== rtl/pnfp_ram.sv =====
// Generic single-port synchronous RAM with a registered read.
// Depends on nothing.
module pnfp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  logic             aclk,
    input  logic             en,
    input  logic             we,
    input  logic [AW-1:0]    addr,
    input  logic [WIDTH-1:0] wdata,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            if (we) begin
                mem[addr] <= wdata;
            end else begin
                rdata_reg <= mem[addr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/pnfp_palette.sv =====
// Palette memory: one write port, two registered read ports, per-entry valid
// bits so that entries never loaded read as zero. Depends on pnfp_pkg.
`include "assert_macros.svh"

module pnfp_palette
    import pnfp_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  pal_req_t           req,
    output logic [COLOR_W-1:0] rdata_even,
    output logic [COLOR_W-1:0] rdata_odd
);

    logic [COLOR_W-1:0]      mem [PALETTE_SIZE];
    logic [PALETTE_SIZE-1:0] valid_reg;
    logic [COLOR_W-1:0]      even_reg;
    logic [COLOR_W-1:0]      odd_reg;
    logic                    even_ok_reg;
    logic                    odd_ok_reg;

    always_ff @(posedge aclk) begin
        if (req.we) begin
            mem[req.waddr] <= req.wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (req.we) begin
            valid_reg[req.waddr] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (req.re) begin
            even_reg    <= mem[req.raddr_even];
            odd_reg     <= mem[req.raddr_odd];
            even_ok_reg <= valid_reg[req.raddr_even];
            odd_ok_reg  <= valid_reg[req.raddr_odd];
        end
    end

    assign rdata_even = even_ok_reg ? even_reg : '0;
    assign rdata_odd  = odd_ok_reg ? odd_reg : '0;

    `PNFP_ASSERT_CLK(a_no_rw_overlap, aclk, aresetn, !(req.we && req.re), "palette read and write overlap")

endmodule
